// ----- src/ffrm_pkg.sv -----
// ----------------------------------------------------------------------------
// ffrm_pkg
// Shared types and constants for the FIFO work list with remove and
// membership query.
// ----------------------------------------------------------------------------
package ffrm_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ENQ      = 2'd0,
        CMD_DEQ      = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_CONTAINS = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                en;
        logic [PTR_W-1:0]    addr;
        logic [KEY_BITS-1:0] data;
    } ffrm_wr_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
    } ffrm_rd_t;

endpackage

// ----- src/ffrm_store.sv -----
// ----------------------------------------------------------------------------
// ffrm_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffrm_store
    import ffrm_pkg::*;
(
    input  logic                clk,
    input  ffrm_wr_t            wr,
    input  ffrm_rd_t            rd,
    output logic [KEY_BITS-1:0] rdata
);

    logic [KEY_BITS-1:0] mem_reg [DEPTH];
    logic [KEY_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem_reg[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fifo_with_remove_and_membership.sv -----
// ----------------------------------------------------------------------------
// fifo_with_remove_and_membership
// Ring-buffer work list of key handles: enqueue, dequeue, remove all copies
// of a key keeping order, and membership query. One result per command.
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tuser
// s_       in   [15:0] key                         [1:0] command
// m_       out  [15:0] key_out, [20:16] occupancy  [0] found, [2:1] status
//
// Enqueue goes through S_FIN to the output register; dequeue first reads the
// store in S_DEQ. Remove / contains walk every stored entry in S_WALK; one stored entry is
// read and compared per cycle through the single store read port.
// One command at a time; s_tready is low from acceptance until the result is
// loaded into the output register. A stalled result holds further commands.
// Reset clears head and count; the store itself is not cleared.
// ----------------------------------------------------------------------------
module fifo_with_remove_and_membership
    import ffrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] key
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] key_out, [20:16] occupancy, rest zero
    output logic [2:0]  m_tuser    // [0] found, [2:1] status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_WALK,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    kept_reg, kept_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic [1:0]          status_reg, status_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic                m_valid_reg, m_valid_next;
    logic [KEY_BITS-1:0] m_key_reg, m_key_next;
    logic                m_found_reg, m_found_next;
    logic [CNT_W-1:0]    m_occ_reg, m_occ_next;
    logic [1:0]          m_status_reg, m_status_next;

    ffrm_wr_t            wr;
    ffrm_rd_t            rd;
    logic [KEY_BITS-1:0] rdata;
    logic                s_hs;
    logic                match;

    ffrm_store u_store (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_hs     = s_tvalid && s_tready;
    assign match    = pend_reg && (rdata == key_reg);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        kept_next     = kept_reg;
        pend_next     = 1'b0;
        found_next    = found_reg;
        status_next   = status_reg;
        res_key_next  = res_key_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_key_next    = m_key_reg;
        m_found_next  = m_found_reg;
        m_occ_next    = m_occ_reg;
        m_status_next = m_status_reg;
        wr            = '0;
        rd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_hs)
                begin
                    cmd_next     = cmd_t'(s_tuser);
                    key_next     = s_tdata[KEY_BITS-1:0];
                    found_next   = 1'b0;
                    status_next  = ST_OK;
                    res_key_next = '0;
                    idx_next     = '0;
                    kept_next    = '0;
                    unique case (cmd_t'(s_tuser))
                        CMD_ENQ:
                        begin
                            state_next = S_FIN;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                wr.addr    = head_reg + count_reg[PTR_W-1:0];
                                wr.data    = s_tdata[KEY_BITS-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                rd.en      = 1'b1;
                                rd.addr    = head_reg;
                                state_next = S_DEQ;
                            end
                        end
                        CMD_REMOVE, CMD_CONTAINS:
                        begin
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                res_key_next = rdata;
                head_next    = head_reg + 1'b1;
                count_next   = count_reg - 1'b1;
                state_next   = S_FIN;
            end
            S_WALK:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                end
                else if (pend_reg && cmd_reg == CMD_REMOVE)
                begin
                    // compaction: write slot trails read slot, no hazard
                    wr.en     = 1'b1;
                    wr.addr   = head_reg + kept_reg[PTR_W-1:0];
                    wr.data   = rdata;
                    kept_next = kept_reg + 1'b1;
                end
                if (idx_reg == count_reg)
                begin
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        count_next = kept_next;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    rd.en     = 1'b1;
                    rd.addr   = head_reg + idx_reg[PTR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_key_next    = res_key_reg;
                    m_found_next  = found_reg;
                    m_occ_next    = count_reg;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        kept_reg     <= kept_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        res_key_reg  <= res_key_next;
        m_key_reg    <= m_key_next;
        m_found_reg  <= m_found_next;
        m_occ_reg    <= m_occ_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(24 - KEY_BITS - CNT_W){1'b0}}, m_occ_reg, m_key_reg};
    assign m_tuser  = {m_status_reg, m_found_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_FULL) |-> (m_occ_reg == CNT_W'(DEPTH)))
        else $error("full status without full queue");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_EMPTY) |-> (m_occ_reg == '0 && m_key_reg == '0))
        else $error("empty status with entries or data");

    a_kept_trails: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (kept_reg <= idx_reg && idx_reg <= count_reg))
        else $error("walk pointers out of order");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && state_next == S_FIN && cmd_reg == CMD_REMOVE
            && !found_next) |=> (count_reg == $past(count_reg)))
        else $error("remove without match changed occupancy");

endmodule

// ----- tb/sv/ffrm_checker.sv -----
// ----------------------------------------------------------------------------
// ffrm_checker
// Watches both stream channels of the FIFO work list. It keeps a shadow ring
// of keys, predicts the reply to every accepted command and compares each
// returned reply, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ffrm_checker
    import ffrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] key
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [15:0] key_out, [20:16] occupancy, rest zero
    input  logic [2:0]  m_tuser,   // [0] found, [2:1] status
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [KEY_BITS-1:0] key_out;
        logic                found;
        logic [CNT_W-1:0]    occupancy;
        logic [1:0]          status;
    } reply_t;

    logic [KEY_BITS-1:0] shadow_slots [DEPTH];
    logic [PTR_W-1:0]    shadow_head;
    logic [CNT_W-1:0]    shadow_count;
    reply_t              predicted_replies [$];

    function automatic logic [PTR_W-1:0] ring_slot(input int pos);
        return PTR_W'((int'(shadow_head) + pos) % DEPTH);
    endfunction

    task automatic work_list_step(input cmd_t cmd, input logic [KEY_BITS-1:0] key,
                                  output reply_t reply);
        int                  kept;
        logic [KEY_BITS-1:0] held;
        reply = '0;
        reply.status = ST_OK;
        case (cmd)
            CMD_ENQ:
                if (shadow_count >= DEPTH)
                    reply.status = ST_FULL;
                else
                begin
                    shadow_slots[ring_slot(shadow_count)] = key;
                    shadow_count++;
                end
            CMD_DEQ:
                if (shadow_count == 0)
                    reply.status = ST_EMPTY;
                else
                begin
                    reply.key_out = shadow_slots[shadow_head];
                    shadow_head   = ring_slot(1);
                    shadow_count--;
                end
            CMD_REMOVE:
            begin
                kept = 0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    held = shadow_slots[ring_slot(i)];
                    if (held == key)
                        reply.found = 1'b1;
                    else
                    begin
                        shadow_slots[ring_slot(kept)] = held;
                        kept++;
                    end
                end
                shadow_count = CNT_W'(kept);
            end
            default:
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_slots[ring_slot(i)] == key)
                        reply.found = 1'b1;
        endcase
        reply.occupancy = shadow_count;
    endtask

    task automatic flag_mismatch(input string what, input reply_t want, input reply_t got);
        if (mismatches < 10)
        begin
            $write("[%0t] %s: expected key_out=%h found=%b occupancy=%0d status=%0d",
                   $realtime, what, want.key_out, want.found, want.occupancy, want.status);
            $display(", got key_out=%h found=%b occupancy=%0d status=%0d",
                     got.key_out, got.found, got.occupancy, got.status);
        end
        mismatches++;
    endtask

    // Handshake signals only move at the rising edge, so the falling edge sees
    // exactly what the next rising edge will accept.
    always @(negedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            shadow_head  = '0;
            shadow_count = '0;
            predicted_replies.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.key_out   = m_tdata[15:0];
                got.occupancy = m_tdata[20:16];
                got.found     = m_tuser[0];
                got.status    = m_tuser[2:1];
                if (predicted_replies.size() == 0)
                    flag_mismatch("reply with no command outstanding", '0, got);
                else
                begin
                    want = predicted_replies.pop_front();
                    if (got.key_out !== want.key_out || got.found !== want.found ||
                        got.occupancy !== want.occupancy || got.status !== want.status)
                        flag_mismatch("reply mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                work_list_step(cmd_t'(s_tuser), s_tdata[KEY_BITS-1:0], want);
                predicted_replies.push_back(want);
            end
            outstanding = predicted_replies.size();
        end
    end

endmodule

// ----- tb/sv/tb_fifo_with_remove_and_membership.sv -----
// ----------------------------------------------------------------------------
// tb_fifo_with_remove_and_membership
// Drives directed and random command streams into the FIFO work list under
// several sender and receiver idling patterns; the checker beside the block
// predicts and compares every reply, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_fifo_with_remove_and_membership;
    import ffrm_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 210;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] key
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] key_out, [20:16] occupancy, rest zero
    logic [2:0]  m_tuser;   // [0] found, [2:1] status

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    logic [KEY_BITS-1:0] key_pool [6];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fifo_with_remove_and_membership u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ffrm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** fifo_with_remove_and_membership: FAILED **");
            $finish;
        end
    end

    task automatic issue(input cmd_t cmd, input logic [KEY_BITS-1:0] key);
        logic taken;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= cmd;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(99) < 75)
            return key_pool[$urandom_range(5)];
        return KEY_BITS'($urandom_range(16'hFFFF));
    endfunction

    // Filling runs push the list towards full, draining runs towards empty.
    function automatic cmd_t pick_cmd(input logic filling);
        int r;
        r = $urandom_range(99);
        if (filling)
            return r < 55 ? CMD_ENQ : r < 70 ? CMD_DEQ : r < 82 ? CMD_REMOVE : CMD_CONTAINS;
        return r < 22 ? CMD_ENQ : r < 62 ? CMD_DEQ : r < 78 ? CMD_REMOVE : CMD_CONTAINS;
    endfunction

    initial
    begin
        int   phase_idle  [4] = '{0, 65, 0, 22};
        int   phase_stall [4] = '{0, 0, 65, 22};
        logic filling;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_ENQ;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_DEQ, 16'h0000);
        issue(CMD_ENQ, 16'h0000);
        issue(CMD_ENQ, 16'hFFFF);
        issue(CMD_CONTAINS, 16'hFFFF);
        issue(CMD_CONTAINS, 16'h5A5A);
        issue(CMD_REMOVE, 16'h5A5A);
        issue(CMD_DEQ, 16'hFFFF);
        issue(CMD_DEQ, 16'h1234);
        // head now sits mid-ring, so the fill wraps
        for (int i = 0; i < DEPTH; i++)
            issue(CMD_ENQ, (i % 3 == 0) ? 16'hA5C3 : KEY_BITS'(16'h1000 + i));
        issue(CMD_ENQ, 16'h7777);
        issue(CMD_REMOVE, 16'hA5C3);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_replies();
            send_idle_pct  = phase_idle[phase];
            recv_stall_pct = phase_stall[phase];
            foreach (key_pool[i])
                key_pool[i] = KEY_BITS'($urandom_range(16'hFFFF));
            key_pool[$urandom_range(5)] = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
            filling = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 30 == 0)
                    filling = 1'($urandom_range(1));
                issue(pick_cmd(filling), pick_key());
            end
        end

        drain_replies();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** fifo_with_remove_and_membership: PASSED **");
        else
            $display("** fifo_with_remove_and_membership: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ffrm_pkg.sv
src/ffrm_store.sv
src/fifo_with_remove_and_membership.sv
tb/sv/ffrm_checker.sv
tb/sv/tb_fifo_with_remove_and_membership.sv
